### hdl/ssra_pkg.sv
package ssra_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int COLUMN_BITS_DEF = 16;

   localparam int COL_PORT_W   = 16;
   localparam int VALUE_W      = 32;
   localparam int COUNT_PORT_W = 7;
   localparam int OP_W         = 3;
   localparam int STATUS_W     = 3;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 56;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_SCALE  = 3'd2,
      OP_REMOVE = 3'd3,
      OP_READ   = 3'd4,
      OP_DUMP   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_SAT       = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_RESOLVE,
      S_INS_RD,
      S_INS_WR,
      S_UPDATE,
      S_RMV_RD,
      S_RMV_WR,
      S_WALK_RD,
      S_WALK_DAT,
      S_SCALE_WR,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               sat;
   } arith_res_type;

endpackage

### hdl/ssra_entry_ram.sv
module ssra_entry_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ssra_arith.sv
module ssra_arith (
   input  logic                                clock,
   input  ssra_pkg::op_type                    op,
   input  logic signed [ssra_pkg::VALUE_W-1:0] acc_value,
   input  logic signed [ssra_pkg::VALUE_W-1:0] operand,
   input  logic signed [ssra_pkg::VALUE_W-1:0] scale_value,
   output ssra_pkg::arith_res_type             addsub_res,
   output ssra_pkg::arith_res_type             scale_res
);

   import ssra_pkg::*;

   localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] NEG_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   logic signed [VALUE_W:0]       sum;
   logic signed [2*VALUE_W-1:0]   product_ff;
   logic signed [2*VALUE_W-17:0]  shifted;
   logic [2*VALUE_W-16-VALUE_W:0] high_bits;

   // saturating add and subtract, read passes the value through
   always_comb begin
      case (op)
         OP_ADD:  sum = {acc_value[VALUE_W-1], acc_value} + {operand[VALUE_W-1], operand};
         OP_SUB:  sum = {acc_value[VALUE_W-1], acc_value} - {operand[VALUE_W-1], operand};
         default: sum = {acc_value[VALUE_W-1], acc_value};
      endcase
      if (sum[VALUE_W] != sum[VALUE_W-1]) begin
         addsub_res.sat   = 1'b1;
         addsub_res.value = sum[VALUE_W] ? NEG_MIN : POS_MAX;
      end else begin
         addsub_res.sat   = 1'b0;
         addsub_res.value = sum[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= scale_value * operand;
   end

   // arithmetic shift floors, then clamp to the value range
   assign shifted   = product_ff[2*VALUE_W-1:16];
   assign high_bits = shifted[2*VALUE_W-17:VALUE_W-1];

   always_comb begin
      if ((&high_bits) || !(|high_bits)) begin
         scale_res.sat   = 1'b0;
         scale_res.value = shifted[VALUE_W-1:0];
      end else begin
         scale_res.sat   = 1'b1;
         scale_res.value = shifted[2*VALUE_W-17] ? NEG_MIN : POS_MAX;
      end
   end

endmodule

### hdl/sorted_sparse_row_accumulator_core.sv
// Keeps one sparse row as (column, value) entries sorted by column in a single
// memory with one read and one write port and a registered read. Add, subtract,
// read and remove scan from the front over the entries below the column, then,
// where an entry is inserted or removed, shift the later entries. Dump reads
// out each entry and emits it; scale scales, writes back and emits each entry.
// The memory needs no clearing after reset. One item is worked at a time; a
// finished result sits in the output register while the next item is taken.
// Only the low COLUMN_BITS bits of the column are kept.
module sorted_sparse_row_accumulator_core #(
   parameter int MAX_ENTRIES = ssra_pkg::MAX_ENTRIES_DEF,
   parameter int COLUMN_BITS = ssra_pkg::COLUMN_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // column [15:0], operand_value [47:16]
   input  logic [ssra_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation [2:0]
   input  logic [ssra_pkg::OP_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_column [15:0], out_value [47:16], entry_count [54:48], zero [55]
   output logic [ssra_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status [2:0]
   output logic [ssra_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                               rsp_tlast
);

   import ssra_pkg::*;

   localparam int COL_W  = (COLUMN_BITS < COL_PORT_W) ? COLUMN_BITS : COL_PORT_W;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int DATA_W = COL_W + VALUE_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [VALUE_W-1:0] opv_ff, opv_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   sh_ff, sh_in;
   logic               found_ff, found_in;
   logic [VALUE_W-1:0] cur_val_ff, cur_val_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [COL_W-1:0]   res_col_ff, res_col_in;
   logic [VALUE_W-1:0] res_val_ff, res_val_in;
   status_type         res_status_ff, res_status_in;
   logic               res_last_ff, res_last_in;

   logic                    rsp_valid_ff;
   logic [COL_PORT_W-1:0]   rsp_col_ff;
   logic [VALUE_W-1:0]      rsp_val_ff;
   status_type              rsp_status_ff;
   logic [COUNT_PORT_W-1:0] rsp_count_ff;
   logic                    rsp_last_ff;

   logic                 out_free;
   logic                 out_load;
   logic [COL_W+15:0]    res_col_ext;
   logic [CNT_W+6:0]     cnt_ext;
   logic [CNT_W-1:0]     sh_minus;
   logic [CNT_W-1:0]     idx_plus;

   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [DATA_W-1:0]    mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [DATA_W-1:0]    mem_rd_data;
   logic [COL_W-1:0]     rd_col;
   logic [VALUE_W-1:0]   rd_val;

   arith_res_type        addsub_res;
   arith_res_type        scale_res;

   ssra_entry_ram #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ssra_arith u_arith (
      .clock       (clock),
      .op          (op_ff),
      .acc_value   (cur_val_ff),
      .operand     (opv_ff),
      .scale_value (rd_val),
      .addsub_res  (addsub_res),
      .scale_res   (scale_res)
   );

   assign rd_col   = mem_rd_data[DATA_W-1:VALUE_W];
   assign rd_val   = mem_rd_data[VALUE_W-1:0];
   assign sh_minus = sh_ff - 1'b1;
   assign idx_plus = idx_ff + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (state_ff == S_EMIT) && out_free;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      col_in        = col_ff;
      opv_in        = opv_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      sh_in         = sh_ff;
      found_in      = found_ff;
      cur_val_in    = cur_val_ff;
      cur_col_in    = cur_col_ff;
      res_col_in    = res_col_ff;
      res_val_in    = res_val_ff;
      res_status_in = res_status_ff;
      res_last_in   = res_last_ff;
      req_tready    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = idx_ff[ADDR_W-1:0];
      mem_wr_data   = {col_ff, {VALUE_W{1'b0}}};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in       = op_type'(req_tuser);
               col_in      = req_tdata[COL_W-1:0];
               opv_in      = req_tdata[COL_PORT_W+VALUE_W-1:COL_PORT_W];
               idx_in      = '0;
               res_last_in = 1'b1;
               unique case (op_type'(req_tuser)) inside
                  OP_ADD, OP_SUB, OP_READ, OP_REMOVE: begin
                     state_in = S_SRCH_RD;
                  end
                  OP_SCALE, OP_DUMP: begin
                     if (cnt_ff == '0) begin
                        res_col_in    = '0;
                        res_val_in    = '0;
                        res_status_in = ST_EMPTY;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_WALK_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            if (idx_ff == cnt_ff) begin
               found_in = 1'b0;
               state_in = S_RESOLVE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (rd_col < col_ff) begin
               idx_in   = idx_plus;
               state_in = S_SRCH_RD;
            end else begin
               found_in   = (rd_col == col_ff);
               cur_val_in = rd_val;
               state_in   = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            res_col_in  = col_ff;
            res_last_in = 1'b1;
            if (op_ff == OP_REMOVE) begin
               if (!found_ff) begin
                  res_val_in    = '0;
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_EMIT;
               end else begin
                  res_val_in    = cur_val_ff;
                  res_status_in = ST_OK;
                  sh_in         = idx_plus;
                  state_in      = S_RMV_RD;
               end
            end else if (found_ff) begin
               state_in = S_UPDATE;
            end else if (cnt_ff == CNT_MAX) begin
               res_val_in    = '0;
               res_status_in = ST_FULL;
               state_in      = S_EMIT;
            end else begin
               sh_in    = cnt_ff;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (sh_ff == idx_ff) begin
               mem_wr_en  = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               cur_val_in = '0;
               state_in   = S_UPDATE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = sh_minus[ADDR_W-1:0];
               state_in    = S_INS_WR;
            end
         end
         S_INS_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sh_ff[ADDR_W-1:0];
            mem_wr_data = mem_rd_data;
            sh_in       = sh_minus;
            state_in    = S_INS_RD;
         end
         S_UPDATE: begin
            mem_wr_en     = (op_ff != OP_READ);
            mem_wr_data   = {col_ff, addsub_res.value};
            res_val_in    = addsub_res.value;
            res_status_in = addsub_res.sat ? ST_SAT : ST_OK;
            state_in      = S_EMIT;
         end
         S_RMV_RD: begin
            if (sh_ff == cnt_ff) begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_EMIT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = sh_ff[ADDR_W-1:0];
               state_in    = S_RMV_WR;
            end
         end
         S_RMV_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sh_minus[ADDR_W-1:0];
            mem_wr_data = mem_rd_data;
            sh_in       = sh_ff + 1'b1;
            state_in    = S_RMV_RD;
         end
         S_WALK_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_WALK_DAT;
         end
         S_WALK_DAT: begin
            cur_col_in  = rd_col;
            res_last_in = (idx_plus == cnt_ff);
            if (op_ff == OP_SCALE) begin
               state_in = S_SCALE_WR;
            end else begin
               res_col_in    = rd_col;
               res_val_in    = rd_val;
               res_status_in = ST_OK;
               state_in      = S_EMIT;
            end
         end
         S_SCALE_WR: begin
            mem_wr_en     = 1'b1;
            mem_wr_data   = {cur_col_ff, scale_res.value};
            res_col_in    = cur_col_ff;
            res_val_in    = scale_res.value;
            res_status_in = scale_res.sat ? ST_SAT : ST_OK;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               if (res_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_plus;
                  state_in = S_WALK_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      col_ff        <= col_in;
      opv_ff        <= opv_in;
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      found_ff      <= found_in;
      cur_val_ff    <= cur_val_in;
      cur_col_ff    <= cur_col_in;
      res_col_ff    <= res_col_in;
      res_val_ff    <= res_val_in;
      res_status_ff <= res_status_in;
      res_last_ff   <= res_last_in;
   end

   assign res_col_ext = {16'b0, res_col_ff};
   assign cnt_ext     = {7'b0, cnt_ff};

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_col_ff    <= res_col_ext[COL_PORT_W-1:0];
         rsp_val_ff    <= res_val_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= cnt_ext[COUNT_PORT_W-1:0];
         rsp_last_ff   <= res_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_val_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CNT_MAX)
      else $error("entry count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == $past(cnt_ff)) || (cnt_ff == $past(cnt_ff) + 1'b1) ||
      (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("entry count moved by more than one");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_RD && sh_ff == idx_ff) |-> (cnt_ff != CNT_MAX))
      else $error("insert into a full row");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_EMIT) |-> !mem_wr_en)
      else $error("memory write outside an operation");

   assert property (@(posedge clock) disable iff (reset)
      (out_load && res_last_ff) |=> (state_ff == S_IDLE))
      else $error("last result not followed by idle");
`endif

endmodule
